### design/cutoff_neighbor_search_macros.svh
// Assertion macros for the file that checks itself.
`ifndef CUTOFF_NEIGHBOR_SEARCH_MACROS_SVH
`define CUTOFF_NEIGHBOR_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CNS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cutoff_neighbor_search: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CNS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cutoff_neighbor_search: next-cycle check failed");

`endif

### design/cns_pkg.sv
package cns_pkg;

	localparam int DEF_MAX_PARTICLES = 1024;
	localparam int DEF_MAX_NEIGHBORS = 64;

	localparam int POS_W  = 32;
	localparam int IDX_W  = 10;
	localparam int CNT_W  = 11;
	localparam int DIST_W = 64;

	localparam logic REG_PARTICLE_COUNT = 1'b0;
	localparam logic REG_CUTOFF_SQUARED = 1'b1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} pos_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] z;
	} mag_t;

	// Magnitude of the difference of two signed coordinates; always fits POS_W bits.
	function automatic logic [POS_W-1:0] abs_diff(logic signed [POS_W-1:0] a,
			logic signed [POS_W-1:0] b);
		logic signed [POS_W:0] d;
		logic signed [POS_W:0] n;
		d = {a[POS_W-1], a} - {b[POS_W-1], b};
		n = -d;
		return d[POS_W] ? n[POS_W-1:0] : d[POS_W-1:0];
	endfunction

endpackage

### design/cutoff_neighbor_search.sv
// A write is stored at its accepting edge. A query reads the queried particle's position,
// then scans each candidate through the distance pipeline, and its last word leaves from the
// finish state; a query of an unused particle goes straight to the finish state.
// Writes are taken one per cycle while idle; one query at a time, one candidate per cycle
// through the single read port of the position memory while the output is not stalled.
// Reset: the control and output registers clear at once, then a clearing pass zeroes memory.
module cutoff_neighbor_search #(
	parameter int MAX_PARTICLES = cns_pkg::DEF_MAX_PARTICLES,
	parameter int MAX_NEIGHBORS = cns_pkg::DEF_MAX_NEIGHBORS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [63:0]              cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     operation,
	input  logic [cns_pkg::IDX_W-1:0] particle_index,
	input  logic signed [31:0]       pos_x_in,
	input  logic signed [31:0]       pos_y_in,
	input  logic signed [31:0]       pos_z_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [cns_pkg::IDX_W-1:0] neighbor_index,
	output logic                     found,
	output logic                     truncated,
	output logic                     last
);
	import cns_pkg::*;

	`include "cutoff_neighbor_search_macros.svh"

	// Address width of the position memory and the width that can hold a count.
	localparam int AW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CW  = $clog2(MAX_PARTICLES + 1);
	localparam int EW  = (CW > CNT_W) ? CW : CNT_W;
	localparam int NW  = $clog2(MAX_NEIGHBORS + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PARTICLES - 1);
	localparam logic [EW-1:0] MAX_EXT   = EW'(MAX_PARTICLES);
	localparam logic [NW-1:0] MAX_N     = NW'(MAX_NEIGHBORS);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_READQ  = 3'd2;
	localparam logic [2:0] ST_WAITQ  = 3'd3;
	localparam logic [2:0] ST_SCAN   = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0]        state_q;
	logic [AW-1:0]     clr_q;
	logic [CNT_W-1:0]  count_q;
	logic [63:0]       cutoff_q;
	logic [EW-1:0]     count_eff;
	logic [EW-1:0]     pi_ext;
	logic [EW-1:0]     scan_q;
	logic [AW-1:0]     qidx_q;
	pos_t              qpos_q;
	logic              pend_v_q;
	logic [AW-1:0]     pend_idx_q;
	logic [NW-1:0]     n_q;
	logic              more_q;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	pos_t              ram_wdata, ram_rdata;

	logic              adv, can_issue, issue;
	logic              dv_s5, dhit_s5, dbusy;
	logic [AW-1:0]     didx_s5;
	logic              take_hit;
	logic              emit_mid, emit_last;

	// Particle count is clipped to memory depth. User must configure only while idle; unenforced.
	assign count_eff = (EW'(count_q) > MAX_EXT) ? MAX_EXT : EW'(count_q);
	assign pi_ext    = EW'(particle_index);

	assign in_ready = (state_q == ST_IDLE);

	// The whole scan pipeline advances only when the output register can take a word, so
	// a hit leaving stage 5 always has somewhere to go.
	assign adv       = !out_valid || out_ready;
	assign can_issue = (scan_q < count_eff) && !more_q;
	assign issue     = (state_q == ST_SCAN) && adv && can_issue;

	// A hit on the queried particle itself, or one after the limit was passed, is dropped.
	assign take_hit = (state_q == ST_SCAN) && adv && dv_s5 && dhit_s5
		&& (didx_s5 != qidx_q) && !more_q;

	// A new hit pushes the parked one out as a plain word, unless the limit is reached.
	// The final word of a query leaves from the finish state.
	assign emit_mid  = take_hit && pend_v_q && (n_q != MAX_N);
	assign emit_last = (state_q == ST_FINISH) && adv;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pi_ext[AW-1:0];
		ram_wdata = '{x: pos_x_in, y: pos_y_in, z: pos_z_in};
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (in_valid && in_ready && (operation == OP_WRITE) && (pi_ext < MAX_EXT)) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re    = (state_q == ST_READQ) || issue;
	assign ram_raddr = (state_q == ST_READQ) ? qidx_q : scan_q[AW-1:0];

	cns_ram #(
		.WIDTH($bits(pos_t)),
		.DEPTH(MAX_PARTICLES)
	) u_pos_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	cns_dist #(
		.AW(AW)
	) u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.issue_valid(issue),
		.issue_index(scan_q[AW-1:0]),
		.cand_pos   (ram_rdata),
		.query_pos  (qpos_q),
		.cutoff     (cutoff_q),
		.valid_s5   (dv_s5),
		.index_s5   (didx_s5),
		.hit_s5     (dhit_s5),
		.busy       (dbusy)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cutoff_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PARTICLE_COUNT: count_q  <= cfg_data[CNT_W-1:0];
				REG_CUTOFF_SQUARED: cutoff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer. Each hit up to the neighbor limit is parked in a pending slot, so that the word
	// before it can go out as a plain word and the final one can carry the last and truncated flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			scan_q     <= '0;
			pend_v_q   <= 1'b0;
			pend_idx_q <= '0;
			n_q        <= '0;
			more_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid && (operation == OP_QUERY)) begin
						scan_q   <= '0;
						pend_v_q <= 1'b0;
						n_q      <= '0;
						more_q   <= 1'b0;
						state_q  <= (pi_ext < count_eff) ? ST_READQ : ST_FINISH;
					end
				end
				ST_READQ: state_q <= ST_WAITQ;
				ST_WAITQ: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (take_hit) begin
						if (!pend_v_q) begin
							pend_v_q   <= 1'b1;
							pend_idx_q <= didx_s5;
							n_q        <= NW'(1);
						end else if (n_q == MAX_N) begin
							more_q <= 1'b1;
						end else begin
							pend_idx_q <= didx_s5;
							n_q        <= n_q + 1'b1;
						end
					end
					if (!can_issue && !dbusy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (adv) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register. A word that is taken clears valid unless a new word replaces it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid      <= 1'b0;
			neighbor_index <= '0;
			found          <= 1'b0;
			truncated      <= 1'b0;
			last           <= 1'b0;
		end else if (emit_mid) begin
			out_valid      <= 1'b1;
			neighbor_index <= IDX_W'(pend_idx_q);
			found          <= 1'b1;
			truncated      <= 1'b0;
			last           <= 1'b0;
		end else if (emit_last) begin
			out_valid      <= 1'b1;
			neighbor_index <= pend_v_q ? IDX_W'(pend_idx_q) : '0;
			found          <= pend_v_q;
			truncated      <= pend_v_q && more_q;
			last           <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Query index and position are captured at acceptance and from the first memory read.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			qidx_q <= pi_ext[AW-1:0];
		end
		if (state_q == ST_WAITQ) begin
			qpos_q <= ram_rdata;
		end
	end

	`CNS_ASSERT_NOW(a_notfound_is_last, out_valid && !found, last)
	`CNS_ASSERT_NOW(a_trunc_is_last, out_valid && truncated, last && found)
	`CNS_ASSERT_NOW(a_idle_pipe_empty, in_ready, !dbusy)
	`CNS_ASSERT_NEXT(a_finish_emits, (state_q == ST_FINISH) && adv, out_valid && last)

endmodule

### design/cns_ram.sv
module cns_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### design/cns_dist.sv
module cns_dist #(
	parameter int AW = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  issue_valid,
	input  logic [AW-1:0]         issue_index,
	input  cns_pkg::pos_t         cand_pos,
	input  cns_pkg::pos_t         query_pos,
	input  logic [63:0]           cutoff,
	output logic                  valid_s5,
	output logic [AW-1:0]         index_s5,
	output logic                  hit_s5,
	output logic                  busy
);
	import cns_pkg::*;

	logic          valid_s1, valid_s2, valid_s3, valid_s4;
	logic [AW-1:0] index_s1, index_s2, index_s3, index_s4;
	mag_t          mag_s2;
	logic [DIST_W-1:0] sqx_s3, sqy_s3, sqz_s3;
	logic [DIST_W+1:0] sum_s4;

	assign busy = valid_s1 | valid_s2 | valid_s3 | valid_s4 | valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Candidate data arrives from the memory in stage 1.
	always_ff @(posedge clk) begin
		if (adv) begin
			index_s1 <= issue_index;
			index_s2 <= index_s1;
			index_s3 <= index_s2;
			index_s4 <= index_s3;
			index_s5 <= index_s4;
			mag_s2.x <= abs_diff(cand_pos.x, query_pos.x);
			mag_s2.y <= abs_diff(cand_pos.y, query_pos.y);
			mag_s2.z <= abs_diff(cand_pos.z, query_pos.z);
			sqx_s3   <= DIST_W'(mag_s2.x) * DIST_W'(mag_s2.x);
			sqy_s3   <= DIST_W'(mag_s2.y) * DIST_W'(mag_s2.y);
			sqz_s3   <= DIST_W'(mag_s2.z) * DIST_W'(mag_s2.z);
			sum_s4   <= (DIST_W+2)'(sqx_s3) + (DIST_W+2)'(sqy_s3) + (DIST_W+2)'(sqz_s3);
			// A sum past 64 bits saturates, which only an all-ones cutoff admits.
			hit_s5   <= ((sum_s4[DIST_W+1:DIST_W] == 2'b00) && (sum_s4[DIST_W-1:0] <= cutoff))
				|| (&cutoff);
		end
	end
endmodule
